// ----- rtl/ults_pkg.sv -----
// Shared types, register indexes and calendar functions for the UTC to local time shift.
`timescale 1ns / 1ps

package ults_pkg;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ZONE_OFFSET = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ZONE_EAST   = 1'b1;
   localparam int unsigned CSR_DATA_WIDTH = 4;

   // Largest offset that still enables conversion.
   localparam logic [3:0] MAX_OFFSET = 4'd12;
   localparam logic [5:0] HOURS_PER_DAY = 6'd24;

   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_DEC = 4'd12;
   localparam logic [4:0] DAY_FIRST = 5'd1;
   localparam logic [4:0] DAY_LAST_DEC = 5'd31;

   // Offsets from 2000 of the century years in range that are not leap years.
   localparam logic [7:0] YEAR_2100 = 8'd100;
   localparam logic [7:0] YEAR_2200 = 8'd200;

   typedef struct packed {
      logic [3:0] zone_offset_hours;
      logic       zone_is_east;
   } cfg_type;

   typedef struct packed {
      logic [7:0] year;
      logic [3:0] month;
      logic [4:0] day;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } stamp_type;

   typedef struct packed {
      stamp_type  stamp;
      logic       converted;
   } result_type;

   // Gregorian leap rule applied to 2000 + year. Since 2000 is a multiple of
   // 400, only 2100 and 2200 are skipped among the multiples of four in range.
   function automatic logic is_leap(input logic [7:0] year);
      is_leap = (year[1:0] == 2'b00) && (year != YEAR_2100) && (year != YEAR_2200);
   endfunction

   // Days in a month; zero for a month code with no meaning.
   function automatic logic [4:0] month_length(input logic [3:0] month,
                                               input logic [7:0] year);
      case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_length = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                     month_length = 5'd30;
         4'd2:    month_length = is_leap(year) ? 5'd29 : 5'd28;
         default: month_length = 5'd0;
      endcase
   endfunction

endpackage

// ----- rtl/ults_csr.sv -----
// Configuration registers for the zone offset and direction.
`timescale 1ns / 1ps

module ults_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [ults_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [ults_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata,
   output ults_pkg::cfg_type                      cfg
);
   import ults_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken.
   assign csr_ready = 1'b1;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ZONE_OFFSET: cfg_in.zone_offset_hours = csr_wdata[3:0];
            CSR_ZONE_EAST:   cfg_in.zone_is_east = csr_wdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.zone_offset_hours <= 4'd0;
         cfg_ff.zone_is_east <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/ults_shift.sv -----
// Combinational hour shift with day, month and year rollover.
`timescale 1ns / 1ps

module ults_shift (
   input  ults_pkg::cfg_type    cfg,
   input  ults_pkg::stamp_type  utc,
   output ults_pkg::result_type local_time
);
   import ults_pkg::*;

   logic       enable;
   logic       month_valid;
   logic [5:0] east_sum;
   logic [5:0] west_wrap;
   logic [4:0] cur_len;
   logic [3:0] prev_month;
   logic [4:0] prev_len;
   logic [7:0] year_next;
   logic [7:0] year_prev;

   // Offsets of zero or above twelve leave the stamp untouched.
   assign enable = (cfg.zone_offset_hours != 4'd0) && (cfg.zone_offset_hours <= MAX_OFFSET);
   assign month_valid = (utc.month >= MONTH_JAN) && (utc.month <= MONTH_DEC);

   assign east_sum   = {1'b0, utc.hour} + {2'b00, cfg.zone_offset_hours};
   assign west_wrap  = {1'b0, utc.hour} + HOURS_PER_DAY - {2'b00, cfg.zone_offset_hours};
   assign cur_len    = month_length(utc.month, utc.year);
   assign prev_month = utc.month - 4'd1;
   assign prev_len   = month_length(prev_month, utc.year);
   assign year_next  = utc.year + 8'd1;
   assign year_prev  = utc.year - 8'd1;

   // Hour shift and, when midnight is crossed and the month code is valid, a one-day step of the date.
   always_comb begin
      local_time.stamp = utc;
      local_time.converted = 1'b0;
      if (enable) begin
         local_time.converted = 1'b1;
         if (cfg.zone_is_east) begin
            if (east_sum < HOURS_PER_DAY) begin
               local_time.stamp.hour = east_sum[4:0];
            end else begin
               local_time.stamp.hour = 5'(east_sum - HOURS_PER_DAY);
               if (cur_len != 5'd0) begin
                  if (utc.day < cur_len) begin
                     local_time.stamp.day = utc.day + 5'd1;
                  end else begin
                     local_time.stamp.day = DAY_FIRST;
                     if (utc.month == MONTH_DEC) begin
                        local_time.stamp.month = MONTH_JAN;
                        local_time.stamp.year = year_next;
                     end else begin
                        local_time.stamp.month = utc.month + 4'd1;
                     end
                  end
               end
            end
         end else begin
            if ({1'b0, utc.hour} >= {2'b00, cfg.zone_offset_hours}) begin
               local_time.stamp.hour = utc.hour - {1'b0, cfg.zone_offset_hours};
            end else begin
               local_time.stamp.hour = west_wrap[4:0];
               if (month_valid) begin
                  if (utc.day > DAY_FIRST) begin
                     local_time.stamp.day = utc.day - 5'd1;
                  end else if (utc.month == MONTH_JAN) begin
                     local_time.stamp.month = MONTH_DEC;
                     local_time.stamp.day = DAY_LAST_DEC;
                     local_time.stamp.year = year_prev;
                  end else begin
                     local_time.stamp.month = prev_month;
                     local_time.stamp.day = prev_len;
                  end
               end
            end
         end
      end
   end

endmodule

// ----- rtl/utc_to_local_time_shift_top.sv -----
// Top level of the UTC to local time shift: request and result registers around the shift logic.
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// req       req_valid / req_stall   req_utc_year .. req_utc_second
// rsp       rsp_valid / rsp_stall   rsp_local_year .. rsp_local_second, rsp_converted
// csr       csr_valid / csr_ready   csr_index, csr_wdata
//
// A request is registered on acceptance and its result is registered in the
// result register through the combinational shift logic between the two
// registers; one request is taken every cycle while rsp_stall is low.
// Reset is synchronous and active high; it empties both stages and loads the
// register defaults (offset 0, east). While a result is stalled an empty request
// register still accepts one more request before req_stall rises.

module utc_to_local_time_shift_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [7:0]                             req_utc_year,
   input  logic [3:0]                             req_utc_month,
   input  logic [4:0]                             req_utc_day,
   input  logic [4:0]                             req_utc_hour,
   input  logic [5:0]                             req_utc_minute,
   input  logic [5:0]                             req_utc_second,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [7:0]                             rsp_local_year,
   output logic [3:0]                             rsp_local_month,
   output logic [4:0]                             rsp_local_day,
   output logic [4:0]                             rsp_local_hour,
   output logic [5:0]                             rsp_local_minute,
   output logic [5:0]                             rsp_local_second,
   output logic                                   rsp_converted,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [ults_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [ults_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);
   import ults_pkg::*;

   cfg_type    cfg;
   logic       in_valid_ff;
   logic       in_valid_in;
   stamp_type  in_data_ff;
   stamp_type  in_data_in;
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type out_data_ff;
   result_type out_data_in;
   result_type shifted;
   logic       out_free;
   logic       advance;
   logic       in_free;
   logic       req_take;

   ults_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ults_shift u_shift (
      .cfg        (cfg),
      .utc        (in_data_ff),
      .local_time (shifted)
   );

   // Flow control between the request register and the result register.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign in_free   = !in_valid_ff || advance;
   assign req_take  = req_valid && in_free;
   assign req_stall = !in_free;

   // Next values of both stages.
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_data_in   = in_data_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (out_free) begin
         out_valid_in = in_valid_ff;
         out_data_in  = shifted;
      end
      if (in_free) begin
         in_valid_in = req_valid;
         in_data_in.year   = req_utc_year;
         in_data_in.month  = req_utc_month;
         in_data_in.day    = req_utc_day;
         in_data_in.hour   = req_utc_hour;
         in_data_in.minute = req_utc_minute;
         in_data_in.second = req_utc_second;
      end
   end

   // Control state is reset; payload registers only load.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= in_data_in;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   // Result ports.
   assign rsp_valid        = out_valid_ff;
   assign rsp_local_year   = out_data_ff.stamp.year;
   assign rsp_local_month  = out_data_ff.stamp.month;
   assign rsp_local_day    = out_data_ff.stamp.day;
   assign rsp_local_hour   = out_data_ff.stamp.hour;
   assign rsp_local_minute = out_data_ff.stamp.minute;
   assign rsp_local_second = out_data_ff.stamp.second;
   assign rsp_converted    = out_data_ff.converted;

endmodule
